[rtl/ccs_pkg.sv]
// ccs_pkg: shared constants, codes and item structs of the categorical cdf sampler
// used by ccs_engine and categorical_cdf_sampler_core; no dependencies
package ccs_pkg;

   localparam int MAX_HIDDEN     = 16;
   localparam int MAX_OBSERVABLE = 64;

   localparam int HID_W    = $clog2(MAX_HIDDEN);
   localparam int OBS_W    = $clog2(MAX_OBSERVABLE);
   localparam int IDX_W    = 6;
   localparam int COL_W    = 4;
   localparam int PROB_W   = 17;
   localparam int HCOUNT_W = 5;
   localparam int OCOUNT_W = 7;

   localparam int EMI_BASE  = 0;
   localparam int TRN_BASE  = EMI_BASE + MAX_HIDDEN * MAX_OBSERVABLE;
   localparam int ROOT_BASE = TRN_BASE + MAX_HIDDEN * MAX_HIDDEN;
   localparam int CDF_DEPTH = ROOT_BASE + MAX_HIDDEN;
   localparam int ADDR_W    = $clog2(CDF_DEPTH);

   localparam logic [PROB_W-1:0] ONE_Q16 = PROB_W'(65536);

   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   localparam logic [1:0] TBL_ROOT       = 2'd0;
   localparam logic [1:0] TBL_TRANSITION = 2'd1;
   localparam logic [1:0] TBL_EMISSION   = 2'd2;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_HIDDEN_COUNT     = 1'b0;
   localparam logic REG_OBSERVABLE_COUNT = 1'b1;

   typedef struct packed {
      logic              op;
      logic [1:0]        table_select;
      logic [IDX_W-1:0]  row;
      logic [COL_W-1:0]  column;
      logic [PROB_W-1:0] value;
   } req_item_type;

   typedef struct packed {
      logic [IDX_W-1:0] hid_last;
      logic [IDX_W-1:0] obs_last;
   } row_limits_type;

   typedef struct packed {
      logic             strobe;
      logic [IDX_W-1:0] sampled_index;
      logic             was_load;
      logic             saturated;
   } rsp_item_type;

endpackage

[rtl/ccs_engine.sv]
// ccs_engine: cdf memory, running sum for loads and the binary search sequencer
// depends on ccs_pkg
module ccs_engine
   import ccs_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  req_item_type   req_item,
   input  row_limits_type limits,
   output logic           busy,
   output rsp_item_type   rsp_item
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_LOAD  = 2'd1;
   localparam logic [1:0] ST_ISSUE = 2'd2;
   localparam logic [1:0] ST_WAIT  = 2'd3;

   logic [1:0]        state_ff, state_in;
   req_item_type      item_ff, item_in;
   logic [IDX_W-1:0]  lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   logic [ADDR_W-1:0] base_ff, base_in;
   logic [PROB_W-1:0] sum_ff, sum_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   logic [IDX_W-1:0]  rsp_index_ff, rsp_index_in;
   logic              rsp_load_ff, rsp_load_in, rsp_sat_ff, rsp_sat_in;

   logic [PROB_W-1:0] cdf_mem [CDF_DEPTH];
   logic [PROB_W-1:0] rdata_ff;
   logic              mem_we, mem_re;
   logic [ADDR_W-1:0] wr_addr, rd_addr;

   logic [PROB_W:0]   sum_wide;
   logic              sum_sat;
   logic [PROB_W-1:0] sum_clip;
   logic [IDX_W-1:0]  step_lo, step_hi;
   logic              accept;

   function automatic logic [IDX_W-1:0] midpoint(input logic [IDX_W-1:0] a,
                                                input logic [IDX_W-1:0] b);
      logic [IDX_W:0] total;
      total = {1'b0, a} + {1'b0, b};
      return total[IDX_W:1];
   endfunction

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   always_comb begin
      sum_wide = (item_ff.row == '0) ? {1'b0, item_ff.value}
                                     : {1'b0, sum_ff} + {1'b0, item_ff.value};
      sum_sat  = (sum_wide > {1'b0, ONE_Q16});
      sum_clip = sum_sat ? ONE_Q16 : sum_wide[PROB_W-1:0];
      if (rdata_ff < item_ff.value) begin
         step_lo = mid_ff + IDX_W'(1);
         step_hi = hi_ff;
      end else begin
         step_lo = lo_ff;
         step_hi = mid_ff;
      end
   end

   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      base_in       = base_ff;
      sum_in        = sum_ff;
      rsp_strobe_in = 1'b0;
      rsp_index_in  = rsp_index_ff;
      rsp_load_in   = rsp_load_ff;
      rsp_sat_in    = rsp_sat_ff;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      rd_addr       = base_ff + ADDR_W'(mid_ff);
      wr_addr       = ADDR_W'(ROOT_BASE) + ADDR_W'(item_ff.row[HID_W-1:0]);
      case (item_ff.table_select)
         TBL_TRANSITION: wr_addr = ADDR_W'(TRN_BASE)
                                   + ADDR_W'(item_ff.column[HID_W-1:0]) * ADDR_W'(MAX_HIDDEN)
                                   + ADDR_W'(item_ff.row[HID_W-1:0]);
         TBL_EMISSION:   wr_addr = ADDR_W'(EMI_BASE)
                                   + ADDR_W'(item_ff.column[HID_W-1:0])
                                     * ADDR_W'(MAX_OBSERVABLE)
                                   + ADDR_W'(item_ff.row[OBS_W-1:0]);
         default:        ;
      endcase
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               item_in = req_item;
               lo_in   = '0;
               if (req_item.op == OP_LOAD) begin
                  state_in = ST_LOAD;
               end else begin
                  state_in = ST_ISSUE;
                  case (req_item.table_select)
                     TBL_ROOT: begin
                        hi_in   = limits.hid_last;
                        base_in = ADDR_W'(ROOT_BASE);
                     end
                     TBL_TRANSITION: begin
                        hi_in   = limits.hid_last;
                        base_in = ADDR_W'(TRN_BASE) + ADDR_W'(req_item.column[HID_W-1:0])
                                  * ADDR_W'(MAX_HIDDEN);
                     end
                     TBL_EMISSION: begin
                        hi_in   = limits.obs_last;
                        base_in = ADDR_W'(EMI_BASE) + ADDR_W'(req_item.column[HID_W-1:0])
                                  * ADDR_W'(MAX_OBSERVABLE);
                     end
                     default: begin
                        hi_in   = '0;
                        base_in = '0;
                     end
                  endcase
               end
            end
         end
         ST_LOAD: begin
            state_in      = ST_IDLE;
            rsp_strobe_in = 1'b1;
            rsp_index_in  = item_ff.row;
            rsp_load_in   = 1'b1;
            rsp_sat_in    = 1'b0;
            case (item_ff.table_select)
               TBL_ROOT, TBL_TRANSITION: begin
                  sum_in     = sum_clip;
                  rsp_sat_in = sum_sat;
                  mem_we     = ({1'b0, item_ff.row} < (IDX_W+1)'(MAX_HIDDEN));
               end
               TBL_EMISSION: begin
                  sum_in     = sum_clip;
                  rsp_sat_in = sum_sat;
                  mem_we     = ({1'b0, item_ff.row} < (IDX_W+1)'(MAX_OBSERVABLE));
               end
               default: ;
            endcase
         end
         ST_ISSUE: begin
            if (lo_ff == hi_ff) begin
               state_in      = ST_IDLE;
               rsp_strobe_in = 1'b1;
               rsp_index_in  = lo_ff;
               rsp_load_in   = 1'b0;
               rsp_sat_in    = 1'b0;
            end else begin
               mid_in   = midpoint(lo_ff, hi_ff);
               rd_addr  = base_ff + ADDR_W'(mid_in);
               mem_re   = 1'b1;
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            lo_in = step_lo;
            hi_in = step_hi;
            if (step_lo == step_hi) begin
               state_in      = ST_IDLE;
               rsp_strobe_in = 1'b1;
               rsp_index_in  = step_lo;
               rsp_load_in   = 1'b0;
               rsp_sat_in    = 1'b0;
            end else begin
               mid_in  = midpoint(step_lo, step_hi);
               rd_addr = base_ff + ADDR_W'(mid_in);
               mem_re  = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         cdf_mem[wr_addr] <= sum_clip;
      end
      if (mem_re) begin
         rdata_ff <= cdf_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         sum_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sum_ff        <= sum_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      base_ff      <= base_in;
      rsp_index_ff <= rsp_index_in;
      rsp_load_ff  <= rsp_load_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   assign rsp_item = '{strobe:        rsp_strobe_ff,
                       sampled_index: rsp_index_ff,
                       was_load:      rsp_load_ff,
                       saturated:     rsp_sat_ff};

   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(state_ff != ST_IDLE))
      else $error("result strobe without an item in progress");

   a_search_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WAIT) |-> (lo_ff <= mid_ff) && (mid_ff < hi_ff))
      else $error("search probe outside its interval");

   a_sum_bound: assert property (@(posedge clock) disable iff (reset)
      sum_ff <= ONE_Q16)
      else $error("running sum above one");

   a_write_only_on_load: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_LOAD) && !mem_re)
      else $error("cdf write outside a load");

endmodule

[rtl/categorical_cdf_sampler_core.sv]
// categorical_cdf_sampler_core: top level with register port and item channels
// depends on ccs_pkg and ccs_engine
// sequence: a load passes through the load state before its result strobe, a sample through the issue
// state and, unless its range holds one row, the wait state, with one memory read per search step
// throughput: one item at a time, busy until its result is out; the receiver cannot stall
// reset: synchronous; counts return to 16 and 64, running sum to zero, cdf memory not cleared
module categorical_cdf_sampler_core
   import ccs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_op,
   input  logic [1:0]            req_table_select,
   input  logic [IDX_W-1:0]      req_row,
   input  logic [COL_W-1:0]      req_column,
   input  logic [PROB_W-1:0]     req_value,
   output logic                  rsp_strobe,
   output logic [IDX_W-1:0]      rsp_sampled_index,
   output logic                  rsp_was_load,
   output logic                  rsp_saturated,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   logic [HCOUNT_W-1:0] hidden_count_ff, hidden_count_in;
   logic [OCOUNT_W-1:0] observable_count_ff, observable_count_in;
   logic                csr_write;
   logic                csr_index;
   row_limits_type      limits;
   req_item_type        req_item;
   rsp_item_type        rsp_item;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = paddr[CSR_ADDR_W-1];

   always_comb begin
      hidden_count_in     = hidden_count_ff;
      observable_count_in = observable_count_ff;
      if (csr_write) begin
         case (csr_index)
            REG_HIDDEN_COUNT:     hidden_count_in     = pwdata[HCOUNT_W-1:0];
            REG_OBSERVABLE_COUNT: observable_count_in = pwdata[OCOUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_HIDDEN_COUNT:     prdata = CSR_DATA_W'(hidden_count_ff);
         REG_OBSERVABLE_COUNT: prdata = CSR_DATA_W'(observable_count_ff);
         default:              prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hidden_count_ff     <= HCOUNT_W'(MAX_HIDDEN);
         observable_count_ff <= OCOUNT_W'(MAX_OBSERVABLE);
      end else begin
         hidden_count_ff     <= hidden_count_in;
         observable_count_ff <= observable_count_in;
      end
   end

   // last row searched, count clamped to 1 .. table depth
   always_comb begin
      if (hidden_count_ff == '0) begin
         limits.hid_last = '0;
      end else if (32'(hidden_count_ff) > MAX_HIDDEN) begin
         limits.hid_last = IDX_W'(MAX_HIDDEN - 1);
      end else begin
         limits.hid_last = IDX_W'(hidden_count_ff - HCOUNT_W'(1));
      end
      if (observable_count_ff == '0) begin
         limits.obs_last = '0;
      end else if (32'(observable_count_ff) > MAX_OBSERVABLE) begin
         limits.obs_last = IDX_W'(MAX_OBSERVABLE - 1);
      end else begin
         limits.obs_last = IDX_W'(observable_count_ff - OCOUNT_W'(1));
      end
   end

   assign req_item = '{op:           req_op,
                       table_select: req_table_select,
                       row:          req_row,
                       column:       req_column,
                       value:        req_value};

   ccs_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_item (req_item),
      .limits   (limits),
      .busy     (busy),
      .rsp_item (rsp_item)
   );

   assign rsp_strobe        = rsp_item.strobe;
   assign rsp_sampled_index = rsp_item.sampled_index;
   assign rsp_was_load      = rsp_item.was_load;
   assign rsp_saturated     = rsp_item.saturated;

endmodule

[test/tb.sv]
// tb: self-checking testbench for categorical_cdf_sampler_core, loads cdf columns and draws
// samples through the command channel and checks every result against its own predictor
// depends on ccs_pkg and categorical_cdf_sampler_core
`timescale 1ns / 1ps

module tb;
   import ccs_pkg::*;

   localparam logic [1:0] TBL_NONE = 2'd3;
   localparam int STALL_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 16;

   typedef struct packed {
      logic [IDX_W-1:0] index;
      logic             was_load;
      logic             saturated;
   } outcome_type;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic                  req_op = OP_LOAD;
   logic [1:0]            req_table_select = '0;
   logic [IDX_W-1:0]      req_row = '0;
   logic [COL_W-1:0]      req_column = '0;
   logic [PROB_W-1:0]     req_value = '0;
   logic                  rsp_strobe;
   logic [IDX_W-1:0]      rsp_sampled_index;
   logic                  rsp_was_load;
   logic                  rsp_saturated;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   categorical_cdf_sampler_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_op(req_op), .req_table_select(req_table_select), .req_row(req_row),
      .req_column(req_column), .req_value(req_value),
      .rsp_strobe(rsp_strobe), .rsp_sampled_index(rsp_sampled_index),
      .rsp_was_load(rsp_was_load), .rsp_saturated(rsp_saturated),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // predictor state
   logic [PROB_W-1:0] root_levels [MAX_HIDDEN];
   logic [PROB_W-1:0] trans_levels [MAX_HIDDEN*MAX_HIDDEN];
   logic [PROB_W-1:0] emit_levels [MAX_HIDDEN*MAX_OBSERVABLE];
   logic [PROB_W-1:0] acc_sum = '0;
   int n_hidden = 16;
   int n_observable = 64;

   // which entries the stimulus has written so far
   bit root_filled [MAX_HIDDEN];
   bit trans_filled [MAX_HIDDEN][MAX_HIDDEN];
   bit emit_filled [MAX_HIDDEN][MAX_OBSERVABLE];

   req_item_type item_backlog [$];
   outcome_type  pending_outcomes [$];
   outcome_type  want;
   logic         offer_taken = 1'b0;
   int           taken_total = 0;
   int           queued_total = 0;
   int           mismatch_count = 0;
   int           quiet_cycles = 0;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic int rows_searched(logic [1:0] sel);
      int c;
      int depth;
      if (sel == TBL_NONE) return 1;
      c = (sel == TBL_EMISSION) ? n_observable : n_hidden;
      depth = (sel == TBL_EMISSION) ? MAX_OBSERVABLE : MAX_HIDDEN;
      if (c < 1) return 1;
      if (c > depth) return depth;
      return c;
   endfunction

   function automatic outcome_type sampler_outcome(req_item_type it);
      outcome_type res;
      logic [PROB_W:0] total;
      logic [PROB_W-1:0] level;
      int lo;
      int hi;
      int mid;
      res = '0;
      if (it.op == OP_LOAD) begin
         res.index = it.row;
         res.was_load = 1'b1;
         if (it.table_select != TBL_NONE) begin
            total = (it.row == 0) ? {1'b0, it.value}
                                  : {1'b0, acc_sum} + {1'b0, it.value};
            if (total > {1'b0, ONE_Q16}) begin
               total = {1'b0, ONE_Q16};
               res.saturated = 1'b1;
            end
            acc_sum = total[PROB_W-1:0];
            case (it.table_select)
               TBL_ROOT: begin
                  if (it.row < MAX_HIDDEN) root_levels[it.row[HID_W-1:0]] = acc_sum;
               end
               TBL_TRANSITION: begin
                  if (it.row < MAX_HIDDEN)
                     trans_levels[it.column*MAX_HIDDEN + it.row] = acc_sum;
               end
               default: begin
                  if (it.row < MAX_OBSERVABLE)
                     emit_levels[it.column*MAX_OBSERVABLE + it.row] = acc_sum;
               end
            endcase
         end
      end else begin
         lo = 0;
         hi = rows_searched(it.table_select) - 1;
         while (lo != hi) begin
            mid = (lo + hi) / 2;
            case (it.table_select)
               TBL_ROOT:       level = root_levels[mid];
               TBL_TRANSITION: level = trans_levels[it.column*MAX_HIDDEN + mid];
               default:        level = emit_levels[it.column*MAX_OBSERVABLE + mid];
            endcase
            if (level < it.value) lo = mid + 1;
            else hi = mid;
         end
         res.index = IDX_W'(lo);
      end
      return res;
   endfunction

   task automatic flag_field(input string name, input int expected, input int actual);
      if (expected != actual) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expected, actual);
         mismatch_count++;
      end
   endtask

   // driver
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && !offer_taken) begin
         start <= 1'b1;
      end else if (item_backlog.size() != 0 &&
                   ((taken_total >= 500 && taken_total < 800) ||
                    $urandom_range(0, 99) >= 29)) begin
         start <= 1'b1;
         req_op <= item_backlog[0].op;
         req_table_select <= item_backlog[0].table_select;
         req_row <= item_backlog[0].row;
         req_column <= item_backlog[0].column;
         req_value <= item_backlog[0].value;
      end else begin
         start <= 1'b0;
      end
   end

   // monitor and prediction
   always @(posedge clock) begin
      offer_taken <= !reset && start && !busy;
      if (!reset && rsp_strobe) begin
         if (pending_outcomes.size() == 0) begin
            $display("%0t: result with none expected, actual index %0d load %0b sat %0b",
                     $time, rsp_sampled_index, rsp_was_load, rsp_saturated);
            mismatch_count++;
         end else begin
            want = pending_outcomes.pop_front();
            flag_field("sampled_index", want.index, rsp_sampled_index);
            flag_field("was_load", want.was_load, rsp_was_load);
            flag_field("saturated", want.saturated, rsp_saturated);
         end
      end
      if (!reset && start && !busy) begin
         pending_outcomes.push_back(sampler_outcome('{req_op, req_table_select, req_row,
                                                      req_column, req_value}));
         void'(item_backlog.pop_front());
         taken_total++;
      end
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe || (psel && penable)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      while (quiet_cycles < STALL_LIMIT) @(posedge clock);
      $display("CHECK FAILED");
      $finish;
   end

   task automatic push_item(input logic op, input logic [1:0] sel, input int row,
                            input int col, input int val);
      req_item_type it;
      it.op = op;
      it.table_select = sel;
      it.row = IDX_W'(row);
      it.column = COL_W'(col);
      it.value = PROB_W'(val);
      if (op == OP_LOAD) begin
         case (sel)
            TBL_ROOT: begin
               if (row < MAX_HIDDEN) root_filled[row] = 1'b1;
            end
            TBL_TRANSITION: begin
               if (row < MAX_HIDDEN) trans_filled[col][row] = 1'b1;
            end
            TBL_EMISSION: begin
               emit_filled[col][row] = 1'b1;
            end
            default: begin
            end
         endcase
      end
      item_backlog.push_back(it);
      queued_total++;
   endtask

   function automatic bit column_ready(logic [1:0] sel, int col);
      int n;
      n = rows_searched(sel);
      for (int r = 0; r < n; r++) begin
         case (sel)
            TBL_ROOT:       if (!root_filled[r]) return 1'b0;
            TBL_TRANSITION: if (!trans_filled[col][r]) return 1'b0;
            TBL_EMISSION:   if (!emit_filled[col][r]) return 1'b0;
            default: begin
            end
         endcase
      end
      return 1'b1;
   endfunction

   function automatic int draw_value();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 20) return 65536;
      if (roll < 30) return 0;
      if (roll < 60) return 1024 * $urandom_range(0, 64);
      return $urandom_range(0, 65536);
   endfunction

   task automatic csr_access(input logic wr, input int addr, input logic [31:0] data,
                             output logic [31:0] rd);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= wr;
      paddr <= CSR_ADDR_W'(addr);
      pwdata <= data;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      rd = prdata;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic set_counts(input int h, input int o);
      logic [31:0] word;
      logic [31:0] back;
      int mask;
      int addr;
      for (int k = 0; k < 2; k++) begin
         mask = k ? 127 : 31;
         addr = 4 * (k ? int'(REG_OBSERVABLE_COUNT) : int'(REG_HIDDEN_COUNT));
         word = ($urandom() & ~mask) | ((k ? o : h) & mask);
         csr_access(1'b1, addr, word, back);
         if (k) n_observable = word & mask;
         else n_hidden = word & mask;
         csr_access(1'b0, addr, '0, back);
         flag_field(k ? "observable_count" : "hidden_count", word & mask, back);
      end
   endtask

   task automatic wait_idle();
      while (item_backlog.size() != 0 || pending_outcomes.size() != 0 || start || busy)
         @(posedge clock);
   endtask

   task automatic run_phase(input int quota);
      int first;
      int roll;
      logic [1:0] sel;
      int col;
      int len;
      int depth;
      int top;
      int tries;
      bit coarse;
      bit found;
      first = queued_total;
      while (queued_total - first < quota) begin
         roll = $urandom_range(0, 99);
         if (roll < 45) begin
            // a column from row 0 upwards, rows in ascending order, at least as many rows as are searched
            sel = 2'($urandom_range(0, 2));
            col = $urandom_range(0, 15);
            depth = (sel == TBL_EMISSION) ? MAX_OBSERVABLE : MAX_HIDDEN;
            len = $urandom_range(rows_searched(sel), depth);
            coarse = $urandom_range(0, 1);
            top = 131072 / len;
            if (top > 65536) top = 65536;
            for (int r = 0; r < len; r++)
               push_item(OP_LOAD, sel, r, col,
                         coarse ? 1024 * $urandom_range(0, 128 / len)
                                : $urandom_range(0, top));
         end else if (roll < 85) begin
            found = 1'b0;
            tries = 0;
            while (!found && tries < 8) begin
               sel = 2'($urandom_range(0, 2));
               col = $urandom_range(0, 15);
               found = column_ready(sel, col);
               tries++;
            end
            if (found) begin
               len = $urandom_range(1, 8);
               for (int s = 0; s < len; s++)
                  push_item(OP_SAMPLE, sel, $urandom_range(0, 63), col, draw_value());
            end
         end else begin
            // stray single item
            sel = 2'($urandom_range(0, 3));
            col = $urandom_range(0, 15);
            if ($urandom_range(0, 1) && (sel == TBL_NONE || column_ready(sel, col)))
               push_item(OP_SAMPLE, sel, $urandom_range(0, 63), col, draw_value());
            else
               push_item(OP_LOAD, sel, $urandom_range(0, 63), col,
                         $urandom_range(0, 3) == 0 ? 65536 : $urandom_range(0, 65536));
         end
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      push_item(OP_LOAD, TBL_NONE, 0, 0, 65536);
      push_item(OP_SAMPLE, TBL_NONE, 63, 15, 65536);
      for (int r = 0; r < MAX_HIDDEN; r++)
         push_item(OP_LOAD, TBL_ROOT, r, r,
                   r == 1 ? 65535 : r == 2 ? 1 : r == 3 ? 65536 : 0);
      push_item(OP_SAMPLE, TBL_ROOT, 0, 0, 0);
      push_item(OP_SAMPLE, TBL_ROOT, 0, 0, 1);
      push_item(OP_SAMPLE, TBL_ROOT, 0, 0, 65535);
      push_item(OP_SAMPLE, TBL_ROOT, 0, 0, 65536);
      // rows past the end of storage only move the running sum
      push_item(OP_LOAD, TBL_TRANSITION, 63, 15, 65536);
      push_item(OP_LOAD, TBL_ROOT, 40, 0, 0);

      run_phase(220);
      wait_idle();
      set_counts(31, 127);
      run_phase(220);
      wait_idle();
      set_counts(0, 0);
      run_phase(220);
      wait_idle();
      set_counts(1, 1);
      run_phase(220);
      wait_idle();
      set_counts($urandom_range(0, 31), $urandom_range(0, 127));
      run_phase(220);
      wait_idle();
      set_counts(16, 64);
      run_phase(220);

      wait_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_outcomes.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

[files.f]
rtl/ccs_pkg.sv
rtl/ccs_engine.sv
rtl/categorical_cdf_sampler_core.sv
test/tb.sv
